>>> rtl/core/assert_macros.svh
// Assertion macros shared by the motion sum RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property at every rising edge outside reset.
`define SMFMS_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("smfms check failed");
// Check a property at every rising edge, including reset.
`define SMFMS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("smfms check failed");
`else
`define SMFMS_ASSERT(label, clk, rstn, prop)
`define SMFMS_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> rtl/core/smfms_pkg.sv
// Package for the subsampled frame motion sum unit: widths, defaults,
// register indexes and the raster status type. No dependencies.
`default_nettype none
package smfms_pkg;
    localparam int PIX_W = 8;
    localparam int CFG_W = 13;
    localparam int SUM_W = 25;
    localparam int TDATA_S_W = 16;
    localparam int TDATA_M_W = 32;

    localparam int DEF_SAMPLE_STEP = 10;
    localparam int DEF_MAX_DIMENSION = 4096;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // configuration register indexes
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic sample;     // current raster position is on the sampling grid
        logic frame_end;  // current raster position is the last of the frame
    } raster_status_t;
endpackage
`default_nettype wire

>>> rtl/core/smfms_term.sv
// Difference term: XOR of the two pixels reduced to its highest set bit (one when the pixels are equal).
// Depends on smfms_pkg.
`default_nettype none
module smfms_term
    import smfms_pkg::*;
(
    input  wire logic [PIX_W-1:0] cur_pixel,
    input  wire logic [PIX_W-1:0] prev_pixel,
    output logic      [PIX_W-1:0] term
);
    logic [PIX_W-1:0] diff;

    assign diff = cur_pixel ^ prev_pixel;

    // Isolate the top bit; zero and one both give one.
    always_comb begin
        term = {{(PIX_W-1){1'b0}}, 1'b1};
        for (int i = 1; i < PIX_W; i++) begin
            if (diff[i]) begin
                term = PIX_W'(1) << i;
            end
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/smfms_raster.sv
// Raster position tracker: column, row and sampling phases against the
// configured frame size. Depends on smfms_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module smfms_raster
    import smfms_pkg::*;
#(
    parameter int SAMPLE_STEP   = DEF_SAMPLE_STEP,
    parameter int MAX_DIMENSION = DEF_MAX_DIMENSION
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             advance,
    input  wire logic [CFG_W-1:0] frame_width,
    input  wire logic [CFG_W-1:0] frame_height,
    output raster_status_t        status
);
    localparam int CNT_W   = $clog2(MAX_DIMENSION);
    localparam int PHASE_W = (SAMPLE_STEP > 1) ? $clog2(SAMPLE_STEP) : 1;
    localparam logic [CFG_W-1:0]   MAX_V      = CFG_W'(MAX_DIMENSION);
    localparam logic [CNT_W-1:0]   MAX_LAST   = CNT_W'(MAX_DIMENSION - 1);
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(SAMPLE_STEP - 1);

    logic [CNT_W-1:0]   col_reg, col_next;
    logic [CNT_W-1:0]   row_reg, row_next;
    logic [PHASE_W-1:0] cphase_reg, cphase_next;
    logic [PHASE_W-1:0] rphase_reg, rphase_next;
    logic [CNT_W-1:0]   col_last, row_last;
    logic               last_col, last_row;

    // Last index of a dimension: zero acts as one, oversize as the maximum.
    function automatic logic [CNT_W-1:0] last_index(input logic [CFG_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0) begin
            r = '0;
        end else if (v > MAX_V) begin
            r = MAX_LAST;
        end else begin
            r = CNT_W'(v - CFG_W'(1));
        end
        return r;
    endfunction

    function automatic logic [PHASE_W-1:0] phase_inc(input logic [PHASE_W-1:0] ph);
        logic [PHASE_W-1:0] r;
        if (ph == PHASE_LAST) begin
            r = '0;
        end else begin
            r = ph + PHASE_W'(1);
        end
        return r;
    endfunction

    assign col_last = last_index(frame_width);
    assign row_last = last_index(frame_height);
    // A position at or past the last index counts as last (size change mid-frame).
    assign last_col = (col_reg >= col_last);
    assign last_row = (row_reg >= row_last);

    assign status.sample    = (cphase_reg == '0) && (rphase_reg == '0);
    assign status.frame_end = last_col && last_row;

    always_comb begin
        col_next    = col_reg;
        row_next    = row_reg;
        cphase_next = cphase_reg;
        rphase_next = rphase_reg;
        if (advance) begin
            priority if (last_col && last_row) begin
                col_next    = '0;
                row_next    = '0;
                cphase_next = '0;
                rphase_next = '0;
            end else if (last_col) begin
                col_next    = '0;
                cphase_next = '0;
                row_next    = row_reg + CNT_W'(1);
                rphase_next = phase_inc(rphase_reg);
            end else begin
                col_next    = col_reg + CNT_W'(1);
                cphase_next = phase_inc(cphase_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            row_reg    <= '0;
            cphase_reg <= '0;
            rphase_reg <= '0;
        end else begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            cphase_reg <= cphase_next;
            rphase_reg <= rphase_next;
        end
    end

    `SMFMS_ASSERT(a_wrap_at_frame_end, aclk, aresetn,
        (advance && status.frame_end) |=> (col_reg == '0 && row_reg == '0 && status.sample))
    `SMFMS_ASSERT(a_col_phase_in_range, aclk, aresetn, cphase_reg <= PHASE_LAST)
    `SMFMS_ASSERT(a_row_phase_in_range, aclk, aresetn, rphase_reg <= PHASE_LAST)
endmodule
`default_nettype wire

>>> rtl/core/subsampled_frame_motion_sum_unit.sv
// Subsampled frame motion sum unit, top level.
// Depends on smfms_pkg, smfms_term, smfms_raster and assert_macros.svh.
//
// Usage:
//   s_ channel: one pixel pair per transaction in raster order,
//     s_tdata[7:0] current-frame pixel, s_tdata[15:8] reference pixel.
//   m_ channel: one transaction per frame carrying the frame total in
//     m_tdata[24:0], sent after the frame's last pixel is taken.
//   cfg port: cfg_we / cfg_addr / cfg_wdata write frame_width (index 0) and
//     frame_height (index 1); write them only while the block is idle.
// Throughput: one pixel pair per cycle while s_tready is high, with the raster
//   counters and running sum updated in the accepting cycle.
// Output: the frame total and m_tvalid are registered from the last pixel's
//   transaction and appear in the cycle after it.
// Stall: the output register holds an untaken total; pixels keep flowing
//   until the next frame's last pixel, which waits for the register to free.
// Reset: aresetn low (synchronous) clears counters, sum and m_tvalid and
//   restores the 640 x 480 frame size.
`default_nettype none
`include "assert_macros.svh"
module subsampled_frame_motion_sum_unit
    import smfms_pkg::*;
#(
    parameter int SAMPLE_STEP   = DEF_SAMPLE_STEP,
    parameter int MAX_DIMENSION = DEF_MAX_DIMENSION
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // pixel pair input
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [TDATA_S_W-1:0]  s_tdata,   // [7:0] cur_pixel, [15:8] prev_pixel
    // frame total output
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [TDATA_M_W-1:0]  m_tdata,   // [24:0] motion_sum, rest zero
    // configuration writes
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]      cfg_wdata
);
    logic [CFG_W-1:0]  frame_width_reg;
    logic [CFG_W-1:0]  frame_height_reg;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [SUM_W-1:0]  total_reg, total_next;
    logic              m_valid_reg, m_valid_next;
    logic [PIX_W-1:0]  term;
    logic [SUM_W:0]    sum_wide;
    logic [SUM_W-1:0]  sum_acc;
    logic              s_accept;
    raster_status_t    status;

    // Configuration registers: take the write, masked to the register width.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
            endcase
        end
    end

    smfms_term u_term (
        .cur_pixel  (s_tdata[PIX_W-1:0]),
        .prev_pixel (s_tdata[2*PIX_W-1:PIX_W]),
        .term       (term)
    );

    smfms_raster #(
        .SAMPLE_STEP   (SAMPLE_STEP),
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_raster (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (s_accept),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .status       (status)
    );

    // Only the frame's last pixel needs a free output register.
    assign s_tready = !status.frame_end || !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // Add the term on sampled positions, saturating at the sum width.
    assign sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(term);
    assign sum_acc  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

    always_comb begin
        sum_next     = sum_reg;
        total_next   = total_reg;
        m_valid_next = m_valid_reg && !m_tready;
        if (s_accept) begin
            if (status.sample) begin
                sum_next = sum_acc;
            end
            if (status.frame_end) begin
                // hand the total to the output register and restart the frame
                total_next   = status.sample ? sum_acc : sum_reg;
                sum_next     = '0;
                m_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge aclk) begin
        total_reg <= total_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_M_W'(total_reg);

    `SMFMS_ASSERT(a_total_posted, aclk, aresetn,
        (s_accept && status.frame_end) |=> m_valid_reg)
    `SMFMS_ASSERT(a_no_overwrite, aclk, aresetn,
        (m_valid_reg && !m_tready) |-> !(s_accept && status.frame_end))
    `SMFMS_ASSERT(a_sum_cleared, aclk, aresetn,
        (s_accept && status.frame_end) |=> (sum_reg == '0))
    `SMFMS_ASSERT(a_sum_holds_when_idle, aclk, aresetn,
        (!s_accept && !$past(s_accept)) |-> $stable(sum_reg))
endmodule
`default_nettype wire

>>> verif/tb_top.sv
// Testbench for subsampled_frame_motion_sum_unit: streams pixel pairs and
// predicts every frame motion total, then checks the totals at the output.
// Depends on smfms_pkg and the unit's RTL.
`timescale 1ns / 100ps
module tb_top;
    import smfms_pkg::*;

    localparam int STEP         = DEF_SAMPLE_STEP;
    localparam int MAX_DIM      = DEF_MAX_DIMENSION;
    localparam int QUIET_LIMIT  = 2000;   // cycles without any transaction
    localparam int HOLD_CYCLES  = 300;    // long output stall
    localparam int RANDOM_ITEMS = 470;    // stall phase plus random frames
    localparam int MAX_REPORTS  = 10;

    typedef enum logic {STIM_PIXEL, STIM_WRITE} stim_kind_t;

    typedef struct packed {
        stim_kind_t            kind;
        logic [CFG_ADDR_W-1:0] idx;
        logic [CFG_W-1:0]      value;
        logic [PIX_W-1:0]      cur;
        logic [PIX_W-1:0]      prev;
        logic                  typed;      // total below is written in by hand
        logic [SUM_W-1:0]      total;
    } stim_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [TDATA_S_W-1:0]  s_tdata;    // [7:0] cur_pixel, [15:8] prev_pixel
    logic                  m_tvalid;
    logic                  m_tready;
    logic [TDATA_M_W-1:0]  m_tdata;    // [24:0] motion_sum, rest zero
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;

    // Predicted block state, advanced once per accepted pixel pair
    logic [CFG_W-1:0]  exp_width;
    logic [CFG_W-1:0]  exp_height;
    logic [11:0]       exp_col;
    logic [11:0]       exp_row;
    logic [3:0]        exp_col_ph;
    logic [3:0]        exp_row_ph;
    logic [SUM_W-1:0]  exp_acc;

    // Frame totals still owed by the block, oldest first
    logic [SUM_W-1:0]  frame_total_q[$];

    int send_idle_pct = 35;
    int recv_idle_pct = 71;
    int pixel_count   = 0;
    int frame_count   = 0;
    int write_count   = 0;
    int fail_count    = 0;
    int quiet         = 0;
    int hold_left     = 0;
    bit hold_req      = 1'b0;
    bit hold_used     = 1'b0;

    // Directed rows: reset frame size, mid-frame shrink with a zero height,
    // one-pixel frames that hit every power of two and a zero difference,
    // then a zero width with a two-row frame where only row zero is sampled.
    stim_row_t directed_rows [23] = '{
        //  kind        register          value   cur    prev   typed total
        '{STIM_PIXEL, REG_FRAME_WIDTH,  13'd0, 8'h12, 8'h12, 1'b0, 25'd0},
        '{STIM_PIXEL, REG_FRAME_WIDTH,  13'd0, 8'hFF, 8'h00, 1'b0, 25'd0},
        '{STIM_PIXEL, REG_FRAME_WIDTH,  13'd0, 8'h00, 8'hFF, 1'b0, 25'd0},
        '{STIM_WRITE, REG_FRAME_WIDTH,  13'd2, 8'h00, 8'h00, 1'b0, 25'd0},
        '{STIM_WRITE, REG_FRAME_HEIGHT, 13'd0, 8'h00, 8'h00, 1'b0, 25'd0},
        '{STIM_PIXEL, REG_FRAME_WIDTH,  13'd0, 8'h80, 8'h7F, 1'b1, 25'd1},
        '{STIM_WRITE, REG_FRAME_WIDTH,  13'd1, 8'h00, 8'h00, 1'b0, 25'd0},
        '{STIM_WRITE, REG_FRAME_HEIGHT, 13'd1, 8'h00, 8'h00, 1'b0, 25'd0},
        '{STIM_PIXEL, REG_FRAME_WIDTH,  13'd0, 8'h00, 8'h00, 1'b1, 25'd1},
        '{STIM_PIXEL, REG_FRAME_WIDTH,  13'd0, 8'hFF, 8'h00, 1'b1, 25'd128},
        '{STIM_PIXEL, REG_FRAME_WIDTH,  13'd0, 8'h00, 8'hFF, 1'b1, 25'd128},
        '{STIM_PIXEL, REG_FRAME_WIDTH,  13'd0, 8'h01, 8'h00, 1'b1, 25'd1},
        '{STIM_PIXEL, REG_FRAME_WIDTH,  13'd0, 8'h0F, 8'h0C, 1'b1, 25'd2},
        '{STIM_PIXEL, REG_FRAME_WIDTH,  13'd0, 8'h7F, 8'h7B, 1'b1, 25'd4},
        '{STIM_PIXEL, REG_FRAME_WIDTH,  13'd0, 8'h3C, 8'h34, 1'b1, 25'd8},
        '{STIM_PIXEL, REG_FRAME_WIDTH,  13'd0, 8'h10, 8'h00, 1'b1, 25'd16},
        '{STIM_PIXEL, REG_FRAME_WIDTH,  13'd0, 8'h21, 8'h01, 1'b1, 25'd32},
        '{STIM_PIXEL, REG_FRAME_WIDTH,  13'd0, 8'h20, 8'h60, 1'b1, 25'd64},
        '{STIM_PIXEL, REG_FRAME_WIDTH,  13'd0, 8'h55, 8'hAA, 1'b1, 25'd128},
        '{STIM_WRITE, REG_FRAME_WIDTH,  13'd0, 8'h00, 8'h00, 1'b0, 25'd0},
        '{STIM_WRITE, REG_FRAME_HEIGHT, 13'd2, 8'h00, 8'h00, 1'b0, 25'd0},
        '{STIM_PIXEL, REG_FRAME_WIDTH,  13'd0, 8'h40, 8'h00, 1'b0, 25'd0},
        '{STIM_PIXEL, REG_FRAME_WIDTH,  13'd0, 8'hFF, 8'hFF, 1'b1, 25'd64}
    };

    subsampled_frame_motion_sum_unit #(
        .SAMPLE_STEP   (STEP),
        .MAX_DIMENSION (MAX_DIM)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Advance the predicted raster position for one pixel pair. Return 1 and
    // the frame total when this pixel closes the frame.
    function automatic bit predict_pixel(input logic [PIX_W-1:0] cur,
                                         input logic [PIX_W-1:0] prev,
                                         output logic [SUM_W-1:0] total);
        int               w_eff;
        int               h_eff;
        int               weight;
        int               acc_next;
        bit               col_end;
        bit               row_end;
        logic [PIX_W-1:0] diff;
        // zero sizes act as one, oversized ones clamp to the largest frame
        w_eff = (exp_width == 0) ? 1 : (exp_width > MAX_DIM) ? MAX_DIM : int'(exp_width);
        h_eff = (exp_height == 0) ? 1 : (exp_height > MAX_DIM) ? MAX_DIM : int'(exp_height);
        // a position already past a shrunken edge counts as the edge
        col_end = int'(exp_col) >= w_eff - 1;
        row_end = int'(exp_row) >= h_eff - 1;
        total = '0;
        if (exp_col_ph == 0 && exp_row_ph == 0) begin
            diff = cur ^ prev;
            weight = 1;   // equal pixels still add one
            for (int b = 0; b < PIX_W; b++)
                if (diff[b]) weight = 1 << b;
            acc_next = int'(exp_acc) + weight;
            exp_acc = (acc_next > int'(SUM_MAX)) ? SUM_MAX : SUM_W'(acc_next);
        end
        if (col_end && row_end) begin
            total = exp_acc;
            exp_acc = '0;
            exp_col = '0;
            exp_row = '0;
            exp_col_ph = '0;
            exp_row_ph = '0;
            return 1'b1;
        end
        if (col_end) begin
            exp_col = '0;
            exp_col_ph = '0;
            exp_row = exp_row + 12'd1;
            exp_row_ph = (exp_row_ph + 1 >= STEP) ? 4'd0 : exp_row_ph + 4'd1;
        end else begin
            exp_col = exp_col + 12'd1;
            exp_col_ph = (exp_col_ph + 1 >= STEP) ? 4'd0 : exp_col_ph + 4'd1;
        end
        return 1'b0;
    endfunction

    // Offer one pixel pair, with random gaps before it, and hold it until the
    // transaction completes. Enter and leave at a falling edge; s_tvalid is left
    // high so back-to-back pixels keep it up without a drop.
    task automatic send_pixel(input logic [PIX_W-1:0] cur, input logic [PIX_W-1:0] prev,
                              input bit typed, input logic [SUM_W-1:0] typed_total);
        logic [SUM_W-1:0] total;
        bit               closes_frame;
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {prev, cur};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        closes_frame = predict_pixel(cur, prev, total);
        if (closes_frame || typed)
            frame_total_q.push_back(typed ? typed_total : total);
        pixel_count++;
        @(negedge aclk);
    endtask

    // Drop s_tvalid and pause until every owed total has come out, then let
    // the output stage settle before any register write.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (frame_total_q.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        if (idx == REG_FRAME_WIDTH)
            exp_width = value;
        else
            exp_height = value;
        write_count++;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // Set a frame size and stream random pixel pairs. Pixel content mixes
    // equal pairs, single-bit differences, top-bit differences and noise.
    task automatic run_phase(input int w, input int h, input int count);
        logic [PIX_W-1:0] cur;
        logic [PIX_W-1:0] prev;
        wait_idle();
        write_reg(REG_FRAME_WIDTH, CFG_W'(w));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(h));
        for (int i = 0; i < count; i++) begin
            cur = PIX_W'($urandom_range(255, 0));
            case ($urandom_range(3, 0))
                0: prev = PIX_W'($urandom_range(255, 0));
                1: prev = cur;
                2: prev = cur ^ (8'd1 << $urandom_range(7, 0));
                default: prev = cur ^ 8'h80 ^ PIX_W'($urandom_range(127, 0));
            endcase
            send_pixel(cur, prev, 1'b0, '0);
        end
    endtask

    // Output side: random stalls, plus one long hold-off on request so the
    // output register stays full and the input backs up.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_used) begin
                hold_left = HOLD_CYCLES;
                hold_used = 1'b1;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
            end
        end
    end

    // Compare each frame total transaction against the oldest owed total.
    always @(posedge aclk) begin
        logic [SUM_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            frame_count++;
            if (frame_total_q.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("[%0t] unexpected frame total: got %0d", $realtime,
                             m_tdata[SUM_W-1:0]);
            end else begin
                want = frame_total_q.pop_front();
                if (m_tdata !== TDATA_M_W'(want)) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("[%0t] motion_sum mismatch: expected %0d (0x%h), got 0x%h",
                                 $realtime, want, TDATA_M_W'(want), m_tdata);
                end
            end
        end
    end

    // Watchdog: end the run once no transaction of any kind has happened for
    // too long.
    initial begin
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int w;
        int h;
        int frames;
        int area;
        int count;
        int random_sent;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = REG_FRAME_WIDTH;
        cfg_wdata = '0;
        exp_width  = FRAME_WIDTH_RESET;
        exp_height = FRAME_HEIGHT_RESET;
        exp_col    = '0;
        exp_row    = '0;
        exp_col_ph = '0;
        exp_row_ph = '0;
        exp_acc    = '0;

        // Hold reset, then release it at a falling edge
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed rows; writes only after the block has gone quiet
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == STIM_WRITE) begin
                wait_idle();
                write_reg(directed_rows[i].idx, directed_rows[i].value);
            end else begin
                send_pixel(directed_rows[i].cur, directed_rows[i].prev,
                           directed_rows[i].typed, directed_rows[i].total);
            end
        end

        // One-pixel frames against a long output hold-off: the input must stall.
        // Set the size first so the hold-off starts right before the pixels.
        random_sent = 40;
        run_phase(1, 1, 0);
        hold_req = 1'b1;
        run_phase(1, 1, random_sent);

        // Random frames. Most are small so that many totals come out; each
        // phase stops at a random raster position so the next size lands
        // mid-frame. Idling: sender light / receiver heavy, then swapped,
        // then none.
        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent < RANDOM_ITEMS / 3) begin
                send_idle_pct = 35;
                recv_idle_pct = 71;
            end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 71;
                recv_idle_pct = 35;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if ($urandom_range(9, 0) < 7) begin
                w = $urandom_range(12, 0);
                h = $urandom_range(4, 0);
                frames = $urandom_range(3, 1);
            end else begin
                w = $urandom_range(20, 11);
                h = $urandom_range(12, 11);
                frames = 1;
            end
            area = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
            count = frames * area + $urandom_range(area - 1, 0);
            if (count > RANDOM_ITEMS - random_sent)
                count = RANDOM_ITEMS - random_sent;
            run_phase(w, h, count);
            random_sent += count;
        end

        // Largest sizes: short runs at an oversized width that clamps, at the
        // tallest frame and at a full-size frame, the last one cut short by a
        // shrink in mid-frame.
        run_phase(int'(13'h1FFF), 1, 60);
        run_phase(1, MAX_DIM, 60);
        run_phase(MAX_DIM, int'(13'h1FFF), 40);
        run_phase(3, 2, 4);

        wait_idle();
        repeat (5) @(posedge aclk);
        $display("Run covered %0d pixel pairs, %0d frame totals and %0d register writes,",
                 pixel_count, frame_count, write_count);
        $display("with zero, clamped and mid-frame sizes and a long output stall.");
        if (fail_count == 0 && frame_total_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
